>>> design/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg: shared constants and types of the closest bounded fraction block
// Target width, configuration register indexes and the pipeline status beat.
// ----------------------------------------------------------------------------
`default_nettype none

package cbf_pkg;

  // Target is unsigned fixed point, always this wide.
  localparam int TGT_BITS = 48;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MAX_NUM = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MAX_DEN = 1'b1;

  // Status of the select stage as seen by the sequencer.
  typedef struct packed {
    logic stall;  // best improved, replay the candidate at the multipliers
    logic busy;   // a candidate sits in the compare register
  } pipe_status_t;

endpackage

`default_nettype wire

>>> design/cbf_ifs.sv
// ----------------------------------------------------------------------------
// cbf_ifs: valid/ready channels of the closest bounded fraction block
// Target channel and result channel, each with a source and a sink side.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbf_target_if;
  logic                         valid;
  logic                         ready;
  logic [cbf_pkg::TGT_BITS-1:0] target_value;

  modport source (output valid, output target_value, input ready);
  modport sink   (input valid, input target_value, output ready);
endinterface

interface cbf_result_if #(
  parameter int NUM_BITS = 16,
  parameter int DEN_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [NUM_BITS-1:0] best_numerator;
  logic [DEN_BITS-1:0] best_denominator;

  modport source (output valid, output best_numerator, output best_denominator,
                  input ready);
  modport sink   (input valid, input best_numerator, input best_denominator,
                  output ready);
endinterface

`default_nettype wire

>>> design/cbf_cand.sv
// ----------------------------------------------------------------------------
// cbf_cand: candidate pipeline
// Three register stages per denominator: target times q, nearest clamped
// numerator, then the exact distance |p * 2^F - target * q|.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_cand #(
  parameter int NUM_BITS  = 16,
  parameter int DEN_BITS  = 16,
  parameter int FRAC_BITS = 32,
  parameter int DIST_BITS = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         stall_i,
  input  wire logic                         issue_i,
  input  wire logic [DEN_BITS-1:0]          den_i,
  input  wire logic [cbf_pkg::TGT_BITS-1:0] target_i,
  input  wire logic [NUM_BITS-1:0]          max_num_i,
  output logic                              valid_o,
  output logic [DIST_BITS-1:0]              dist_o,
  output logic [NUM_BITS-1:0]               num_o,
  output logic [DEN_BITS-1:0]               den_o,
  output logic                              busy_o
);

  localparam int TQW = cbf_pkg::TGT_BITS + DEN_BITS;
  localparam int WW  = TQW - FRAC_BITS;
  localparam int CW  = ((WW > NUM_BITS) ? WW : NUM_BITS) + 1;
  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  // stage 1
  logic               v1_q;
  logic [TQW-1:0]     tq1_q, tq1_d;
  logic [DEN_BITS-1:0] q1_q;

  // stage 2
  logic                v2_q, v2_d;
  logic [TQW-1:0]      tq2_q;
  logic [DEN_BITS-1:0] q2_q;
  logic [NUM_BITS-1:0] p2_q, p2_d;

  // stage 3
  logic                 v3_q;
  logic [DIST_BITS-1:0] d3_q, d3_d;
  logic [NUM_BITS-1:0]  p3_q;
  logic [DEN_BITS-1:0]  q3_q;

  logic [WW-1:0]        whole;
  logic [FRAC_BITS-1:0] frac;
  logic [CW-1:0]        whole_c, max_c, p_c;
  logic [DIST_BITS-1:0] pf, tqx;

  assign tq1_d = TQW'(target_i) * TQW'(den_i);

  always_comb begin
    whole   = tq1_q[TQW-1:FRAC_BITS];
    frac    = tq1_q[FRAC_BITS-1:0];
    whole_c = CW'(whole);
    max_c   = CW'(max_num_i);
    if (whole_c > max_c) begin
      p_c = max_c;
    end else begin
      p_c = whole_c + CW'(frac > HALF);
    end
    if (p_c > max_c) begin
      p_c = max_c;
    end
    if (p_c == '0) begin
      p_c = CW'(1);
    end
    p2_d = p_c[NUM_BITS-1:0];
    // no numerator is allowed at all: drop the candidate
    v2_d = v1_q && (max_num_i != '0);
  end

  always_comb begin
    pf  = DIST_BITS'(p2_q) << FRAC_BITS;
    tqx = DIST_BITS'(tq2_q);
    d3_d = (pf < tqx) ? (tqx - pf) : (pf - tqx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (!stall_i) begin
      v1_q <= issue_i;
      v2_q <= v2_d;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      tq1_q <= tq1_d;
      q1_q  <= den_i;
      tq2_q <= tq1_q;
      q2_q  <= q1_q;
      p2_q  <= p2_d;
      d3_q  <= d3_d;
      p3_q  <= p2_q;
      q3_q  <= q2_q;
    end
  end

  assign valid_o = v3_q;
  assign dist_o  = d3_q;
  assign num_o   = p3_q;
  assign den_o   = q3_q;
  assign busy_o  = v1_q | v2_q | v3_q;

endmodule

`default_nettype wire

>>> design/cbf_select.sv
// ----------------------------------------------------------------------------
// cbf_select: cross-multiply and keep the best fraction
// Multiplies each candidate distance against the current best, registers the
// products and replaces the best on a strictly smaller cross product.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_select #(
  parameter int NUM_BITS  = 16,
  parameter int DEN_BITS  = 16,
  parameter int DIST_BITS = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [cbf_pkg::TGT_BITS-1:0] target_i,
  input  wire logic                         valid_i,
  input  wire logic [DIST_BITS-1:0]         dist_i,
  input  wire logic [NUM_BITS-1:0]          num_i,
  input  wire logic [DEN_BITS-1:0]          den_i,
  output cbf_pkg::pipe_status_t             status_o,
  output logic [NUM_BITS-1:0]               best_num_o,
  output logic [DEN_BITS-1:0]               best_den_o
);

  localparam int PW = DIST_BITS + DEN_BITS;

  logic                 v4_q;
  logic [PW-1:0]        lhs4_q, rhs4_q;
  logic [DIST_BITS-1:0] d4_q;
  logic [NUM_BITS-1:0]  p4_q;
  logic [DEN_BITS-1:0]  q4_q;

  logic [NUM_BITS-1:0]  bp_q;
  logic [DEN_BITS-1:0]  bq_q;
  logic [DIST_BITS-1:0] bd_q;

  logic win;

  assign win = v4_q && (lhs4_q < rhs4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      // products in flight used the old best: drop them and replay
      v4_q <= valid_i && !win;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs4_q <= PW'(dist_i) * PW'(bq_q);
    rhs4_q <= PW'(bd_q) * PW'(den_i);
    d4_q   <= dist_i;
    p4_q   <= num_i;
    q4_q   <= den_i;
    if (start_i) begin
      bp_q <= '0;
      bq_q <= DEN_BITS'(1);
      bd_q <= DIST_BITS'(target_i);
    end else if (win) begin
      bp_q <= p4_q;
      bq_q <= q4_q;
      bd_q <= d4_q;
    end
  end

  assign status_o.stall = win;
  assign status_o.busy  = v4_q;
  assign best_num_o     = bp_q;
  assign best_den_o     = bq_q;

endmodule

`default_nettype wire

>>> design/closest_bounded_fraction.sv
// ----------------------------------------------------------------------------
// closest_bounded_fraction: best rational approximation under bounds
// Sequencer, configuration registers and result register around the
// candidate pipeline and the best-fraction select stage.
// ----------------------------------------------------------------------------
// Each target (unsigned, FRAC_BITS fractional bits) returns the fraction p/q
// closest to it with 1 <= q <= max_denominator and p <= max_numerator, starting
// from 0/1; distances are compared exactly, ties keep the smaller denominator.
// One query is in work at a time. Denominators are issued one per cycle, but
// issue stalls for a replay each time the best fraction improves. They enter a
// five-register pipeline (product, numerator, distance, cross products, best).
// A finished result waits in the output register while the next target is
// accepted. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_bounded_fraction #(
  parameter int NUM_BITS  = 16,
  parameter int DEN_BITS  = 16,
  parameter int FRAC_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cbf_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [((NUM_BITS > DEN_BITS) ? NUM_BITS : DEN_BITS)-1:0] cfg_wdata_i,
  cbf_target_if.sink                            tgt_i,
  cbf_result_if.source                          res_o
);

  localparam int DIST_BITS = (NUM_BITS + FRAC_BITS > cbf_pkg::TGT_BITS + DEN_BITS)
                             ? NUM_BITS + FRAC_BITS : cbf_pkg::TGT_BITS + DEN_BITS;
  localparam logic [NUM_BITS-1:0] MAX_NUM_RST = NUM_BITS'(32'd65535);
  localparam logic [DEN_BITS-1:0] MAX_DEN_RST = DEN_BITS'(32'd65535);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [NUM_BITS-1:0]          max_num_q;
  logic [DEN_BITS-1:0]          max_den_q;
  logic [cbf_pkg::TGT_BITS-1:0] tgt_q;
  logic [DEN_BITS-1:0]          den_q, den_d;

  logic                out_valid_q, out_valid_d;
  logic [NUM_BITS-1:0] out_num_q;
  logic [DEN_BITS-1:0] out_den_q;

  logic                  accept, issue, load_out, cand_busy;
  cbf_pkg::pipe_status_t sel_status;

  logic                 c_valid;
  logic [DIST_BITS-1:0] c_dist;
  logic [NUM_BITS-1:0]  c_num;
  logic [DEN_BITS-1:0]  c_den;
  logic [NUM_BITS-1:0]  best_num;
  logic [DEN_BITS-1:0]  best_den;

  assign tgt_i.ready = (state_q == ST_IDLE);
  assign accept      = tgt_i.valid && tgt_i.ready;
  assign issue       = (state_q == ST_RUN) && !sel_status.stall;
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    den_d   = den_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          den_d   = DEN_BITS'(1);
          state_d = (max_den_q == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (den_q == max_den_q) begin
            state_d = ST_DRAIN;
          end else begin
            den_d = den_q + DEN_BITS'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!cand_busy && !sel_status.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      den_q       <= '0;
      out_valid_q <= 1'b0;
      max_num_q   <= MAX_NUM_RST;
      max_den_q   <= MAX_DEN_RST;
    end else begin
      state_q     <= state_d;
      den_q       <= den_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cbf_pkg::CFG_IDX_MAX_NUM: max_num_q <= cfg_wdata_i[NUM_BITS-1:0];
          cbf_pkg::CFG_IDX_MAX_DEN: max_den_q <= cfg_wdata_i[DEN_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_q <= tgt_i.target_value;
    end
    if (load_out) begin
      out_num_q <= best_num;
      out_den_q <= best_den;
    end
  end

  cbf_cand #(
    .NUM_BITS  (NUM_BITS),
    .DEN_BITS  (DEN_BITS),
    .FRAC_BITS (FRAC_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_cand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stall_i   (sel_status.stall),
    .issue_i   (issue),
    .den_i     (den_q),
    .target_i  (tgt_q),
    .max_num_i (max_num_q),
    .valid_o   (c_valid),
    .dist_o    (c_dist),
    .num_o     (c_num),
    .den_o     (c_den),
    .busy_o    (cand_busy)
  );

  cbf_select #(
    .NUM_BITS  (NUM_BITS),
    .DEN_BITS  (DEN_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .target_i   (tgt_i.target_value),
    .valid_i    (c_valid),
    .dist_i     (c_dist),
    .num_i      (c_num),
    .den_i      (c_den),
    .status_o   (sel_status),
    .best_num_o (best_num),
    .best_den_o (best_den)
  );

  assign res_o.valid            = out_valid_q;
  assign res_o.best_numerator   = out_num_q;
  assign res_o.best_denominator = out_den_q;

endmodule

`default_nettype wire
